// ===== rtl/rofir_pkg.sv =====
`timescale 1ns / 1ps
// rofir_pkg: shared types, constants and helpers for the radar object filter / id remap core.
// No dependencies.
package rofir_pkg;

	localparam int unsigned          LOCAL_IDS_DEF = 256;
	localparam longint unsigned      ID_LIMIT_DEF  = 64'd65536;

	localparam int unsigned CFG_AW = 4;
	localparam int unsigned CFG_DW = 32;
	localparam int unsigned GID_W  = 16;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_WINDOW    = 2'd0;
	localparam logic [1:0] REG_DELAY     = 2'd1;
	localparam logic [1:0] REG_NEW_STATE = 2'd2;

	localparam logic [31:0] WINDOW_RST    = 32'd100000;
	localparam logic [31:0] DELAY_RST     = 32'd0;
	localparam logic [2:0]  NEW_STATE_RST = 3'd1;

	typedef struct packed {
		logic [63:0] frame_time;
		logic [63:0] object_time;
		logic [7:0]  local_id;
		logic [2:0]  obj_state;
	} in_item_t;

	typedef struct packed {
		logic              kept;
		logic [GID_W-1:0]  global_id;
		logic [63:0]       corrected_time;
	} out_item_t;

	typedef struct packed {
		logic [31:0] window_us;
		logic [31:0] delay_us;
		logic [2:0]  new_state_code;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic clr_wr;   // write an empty entry at the sweep address
		logic capture;  // register the input item and read its map entry
		logic commit;   // decide, update map/counter, load output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last; // sweep address is at the last entry
		logic out_busy; // output register full and stalled
	} ctrl_sts_t;

	typedef logic [255:0][7:0] lid_tbl_t;

	// local_id modulo n for every 8-bit id, built by counting
	function automatic lid_tbl_t lid_mod_tbl(input int unsigned n);
		lid_tbl_t    t;
		int unsigned r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = 8'(r);
			if (r == n - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return t;
	endfunction

endpackage

// ===== rtl/rofir_ram.sv =====
`timescale 1ns / 1ps
// rofir_ram: generic single-port RAM, registered read.
// No dependencies.
module rofir_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rofir_cfg.sv =====
`timescale 1ns / 1ps
// rofir_cfg: APB-style configuration registers (window, delay, new-object state code).
// Depends on rofir_pkg.
module rofir_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rofir_pkg::CFG_AW-1:0] paddr,
	input  logic [rofir_pkg::CFG_DW-1:0] pwdata,
	output logic [rofir_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output rofir_pkg::cfg_t            cfg
);
	import rofir_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_us      <= WINDOW_RST;
			cfg_q.delay_us       <= DELAY_RST;
			cfg_q.new_state_code <= NEW_STATE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_WINDOW:    cfg_q.window_us      <= pwdata;
				REG_DELAY:     cfg_q.delay_us       <= pwdata;
				REG_NEW_STATE: cfg_q.new_state_code <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WINDOW:    prdata = cfg_q.window_us;
			REG_DELAY:     prdata = cfg_q.delay_us;
			REG_NEW_STATE: prdata = {29'd0, cfg_q.new_state_code};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rofir_ctrl.sv =====
`timescale 1ns / 1ps
// rofir_ctrl: controller FSM: map clear sweep, input capture, lookup and commit.
// Depends on rofir_pkg.
module rofir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rofir_pkg::ctrl_sts_t sts,
	output rofir_pkg::ctrl_cmd_t cmd
);
	import rofir_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// wait here until the output register can take the result
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== rtl/rofir_dp.sv =====
`timescale 1ns / 1ps
// rofir_dp: datapath: time window test, corrected time, id map RAM, global id counter,
// output register. Depends on rofir_pkg and rofir_ram.
module rofir_dp #(
	parameter int unsigned     LOCAL_IDS = rofir_pkg::LOCAL_IDS_DEF,
	parameter longint unsigned ID_LIMIT  = rofir_pkg::ID_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rofir_pkg::cfg_t      cfg,
	input  rofir_pkg::in_item_t  in_data,
	input  rofir_pkg::ctrl_cmd_t cmd,
	output rofir_pkg::ctrl_sts_t sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rofir_pkg::out_item_t out_data
);
	import rofir_pkg::*;

	localparam int unsigned AW    = $clog2(LOCAL_IDS);
	localparam int unsigned CNT_W = $clog2(ID_LIMIT);
	localparam int unsigned EW    = GID_W + 1;
	localparam lid_tbl_t    LID_TBL = lid_mod_tbl(LOCAL_IDS);

	// captured item, first-stage arithmetic
	logic [AW-1:0] lid_s1;
	logic [2:0]    state_s1;
	logic [64:0]   dt_s1;     // object_time - frame_time with borrow
	logic [63:0]   corr_s1;

	logic [AW-1:0]    clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [64:0]      dt;
	logic [64:0]      corr;
	logic [AW-1:0]    in_lid;
	logic [AW-1:0]    ram_addr;
	logic             ram_we;
	logic [EW-1:0]    ram_wdata;
	logic [EW-1:0]    ram_rdata;
	logic [31:0]      win_m1;
	logic             kept;
	logic             new_id;
	logic [CNT_W:0]   cnt_inc;
	logic [CNT_W-1:0] cnt_nx;
	logic [GID_W-1:0] gid_new;
	logic [GID_W-1:0] gid;

	assign dt     = {1'b0, in_data.object_time} - {1'b0, in_data.frame_time};
	assign corr   = {1'b0, in_data.frame_time} - {33'd0, cfg.delay_us};
	assign in_lid = AW'(LID_TBL[in_data.local_id]);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lid_s1   <= in_lid;
			state_s1 <= in_data.obj_state;
			dt_s1    <= dt;
			corr_s1  <= corr[64] ? 64'd0 : corr[63:0];
		end
	end

	// window test: window nonzero, object_time >= frame_time and (object - frame) < window - 1
	assign win_m1 = cfg.window_us - 32'd1;
	assign kept   = !dt_s1[64] && (cfg.window_us != 32'd0)
	                && (dt_s1[63:0] < {32'd0, win_m1});
	assign new_id = kept && (!ram_rdata[EW-1] || (state_s1 == cfg.new_state_code));

	assign cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign cnt_nx  = (cnt_inc >= (CNT_W + 1)'(ID_LIMIT)) ? CNT_W'(1) : cnt_inc[CNT_W-1:0];
	assign gid_new = GID_W'(cnt_nx);
	assign gid     = !kept ? '0 : (new_id ? gid_new : ram_rdata[GID_W-1:0]);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = in_lid;
		if (cmd.clr_wr) begin
			ram_we   = 1'b1;
			ram_addr = clr_q;
		end else if (cmd.commit) begin
			ram_we    = new_id;
			ram_wdata = {1'b1, gid_new};
			ram_addr  = lid_s1;
		end
	end

	rofir_ram #(
		.WIDTH(EW),
		.DEPTH(LOCAL_IDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.re   (cmd.capture),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.commit && new_id) begin
				cnt_q <= cnt_nx;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.kept           <= kept;
			out_q.global_id      <= gid;
			out_q.corrected_time <= corr_s1;
		end
	end

	assign sts.clr_last = (clr_q == AW'(LOCAL_IDS - 1));
	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

// ===== rtl/radar_object_filter_id_remap_core.sv =====
`timescale 1ns / 1ps
// Radar object filter / id remap core: top level.
// Each captured input is committed to the output register once it is not full and stalled.
// Input stalls until the last item commits; the single map RAM port reads, then writes back.
// Reset: registers to defaults, id counter to 0; the id map is then swept empty, all
// LOCAL_IDS entries, in_stall high meanwhile (configuration writes still taken).
module radar_object_filter_id_remap_core #(
	parameter int unsigned     LOCAL_IDS = rofir_pkg::LOCAL_IDS_DEF,
	parameter longint unsigned ID_LIMIT  = rofir_pkg::ID_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  rofir_pkg::in_item_t          in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output rofir_pkg::out_item_t         out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rofir_pkg::CFG_AW-1:0] paddr,
	input  logic [rofir_pkg::CFG_DW-1:0] pwdata,
	output logic [rofir_pkg::CFG_DW-1:0] prdata,
	output logic                         pready
);
	import rofir_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rofir_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	rofir_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	rofir_dp #(
		.LOCAL_IDS(LOCAL_IDS),
		.ID_LIMIT (ID_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
